// ----- rtl/blkta_pkg.sv -----
// Shared types, codes and constants of the block tag allocator.
package blkta_pkg;

  // Parameter defaults
  localparam int NUM_BLOCKS_DEF = 64;
  localparam int OWNER_BITS_DEF = 8;
  localparam int ADDR_BITS_DEF  = 32;

  // Field widths of the stream words
  localparam int CMD_W       = 2;
  localparam int PID_W       = 8;
  localparam int PTR_W       = 32;
  localparam int COUNT_W     = 7;
  localparam int STATUS_W    = 2;
  localparam int IDX_FIELD_W = 6;
  localparam int ADDR_FIELD_W = 32;

  // Input word layout, lowest bit first
  localparam int IN_CMD_LSB   = 0;
  localparam int IN_PID_LSB   = IN_CMD_LSB + CMD_W;
  localparam int IN_PTR_LSB   = IN_PID_LSB + PID_W;
  localparam int IN_COUNT_LSB = IN_PTR_LSB + PTR_W;
  localparam int IN_BITS      = IN_COUNT_LSB + COUNT_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

  // Output word layout, lowest bit first
  localparam int OUT_BITS    = STATUS_W + IDX_FIELD_W + ADDR_FIELD_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int LOG2_W     = 5;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LOG2   = 1'd1;
  localparam logic [CFG_DATA_W-1:0] BASE_RESET = 32'd0;
  localparam logic [LOG2_W-1:0]     LOG2_RESET = 5'd12;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RANGE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAP,          // capture the input word
    OP_CLEAR,        // zero the entry at the write pointer, advance
    OP_ALLOC_INIT,   // load scan pointer with the first-fit start
    OP_FREE_RD,      // read the entry named by the pointer
    OP_RANGE_INIT,   // scan pointer and run length to zero
    OP_SCAN,         // read one entry, advance scan pointer
    OP_CLAIM_HIT,    // mark the checked entry as owned
    OP_RELEASE_HIT,  // clear the checked entry
    OP_CLAIM_INIT,   // load write pointer and length from the found run
    OP_CLAIM_STEP    // mark one entry of the run as owned, advance
  } dp_op_t;

  typedef enum logic {
    SRC_CHK,
    SRC_RUN
  } res_src_t;

  typedef struct packed {
    dp_op_t                op;
    logic                  fin;
    logic [STATUS_W-1:0]   fin_status;
    res_src_t              fin_src;
    logic                  load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] item_cmd;
    logic             start_oob;
    logic             free_oob;
    logic             count_bad;
    logic             chk_vld;
    logic             chk_free;
    logic             chk_own;
    logic             chk_last;
    logic             run_hit;
    logic             claim_last;
    logic             wr_last;
    logic             out_free;
  } dp_stat_t;

endpackage

// ----- rtl/blkta_dp.sv -----
// Datapath: item registers, block table memory, scan counters and result register.
module blkta_dp #(
  parameter int NUM_BLOCKS = blkta_pkg::NUM_BLOCKS_DEF,
  parameter int OWNER_BITS = blkta_pkg::OWNER_BITS_DEF,
  parameter int ADDR_BITS  = blkta_pkg::ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [blkta_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                                cfg_we,
  input  logic [blkta_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [blkta_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  blkta_pkg::dp_cmd_t                  dp_cmd,
  output blkta_pkg::dp_stat_t                 dp_stat,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [blkta_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int IDX_W  = $clog2(NUM_BLOCKS);
  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int WORD_W = OWNER_BITS + 1;

  // Configuration
  logic [blkta_pkg::CFG_DATA_W-1:0] base_r;
  logic [blkta_pkg::LOG2_W-1:0]     log2_r;

  // Captured item
  logic [blkta_pkg::CMD_W-1:0]   item_cmd_r;
  logic [OWNER_BITS-1:0]         item_owner_r;
  logic [blkta_pkg::PTR_W-1:0]   item_ptr_r;
  logic [blkta_pkg::COUNT_W-1:0] item_count_r;

  // Block table: {used, owner}
  logic [WORD_W-1:0] mem_r [NUM_BLOCKS];
  logic [WORD_W-1:0] rd_data_r;
  logic              chk_vld_r;
  logic [IDX_W-1:0]  chk_idx_r;

  logic [CNT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] run_r, run_nxt;
  logic [IDX_W-1:0] run_start_r, run_start_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;

  logic [blkta_pkg::STATUS_W-1:0] res_status_r;
  logic [IDX_W-1:0]               res_idx_r;
  logic                           res_has_r;

  logic                               out_valid_r;
  logic [blkta_pkg::OUT_TDATA_W-1:0]  out_tdata_r;

  logic [blkta_pkg::PTR_W-1:0] idx_full;
  logic                        rd_used;
  logic [OWNER_BITS-1:0]       rd_owner;
  logic [IDX_W-1:0]            run_start_sel;
  logic                        rd_en;
  logic [IDX_W-1:0]            rd_addr;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic [WORD_W-1:0]           wr_data;
  logic [ADDR_BITS-1:0]        addr_sum;
  logic [blkta_pkg::IDX_FIELD_W-1:0]  out_idx;
  logic [blkta_pkg::ADDR_FIELD_W-1:0] out_addr;

  assign idx_full      = item_ptr_r >> log2_r;
  assign rd_used       = rd_data_r[WORD_W-1];
  assign rd_owner      = rd_data_r[OWNER_BITS-1:0];
  assign run_start_sel = (run_r == '0) ? chk_idx_r : run_start_r;

  assign dp_stat.item_cmd  = item_cmd_r;
  assign dp_stat.start_oob = (item_ptr_r != '0) &&
                             (({1'b0, idx_full} + 33'd1) >= 33'(NUM_BLOCKS));
  assign dp_stat.free_oob  = idx_full >= 32'(NUM_BLOCKS);
  assign dp_stat.count_bad = (item_count_r == '0) ||
                             (32'(item_count_r) > 32'(NUM_BLOCKS));
  assign dp_stat.chk_vld   = chk_vld_r;
  assign dp_stat.chk_free  = !rd_used && (rd_owner == '0);
  assign dp_stat.chk_own   = rd_used && (rd_owner == item_owner_r);
  assign dp_stat.chk_last  = chk_idx_r == IDX_W'(NUM_BLOCKS - 1);
  assign dp_stat.run_hit   = chk_vld_r && !rd_used &&
                             ((32'(run_r) + 32'd1) == 32'(item_count_r));
  assign dp_stat.claim_last = left_r == CNT_W'(1);
  assign dp_stat.wr_last   = wr_ptr_r == IDX_W'(NUM_BLOCKS - 1);
  assign dp_stat.out_free  = !out_valid_r || out_tready;

  // Table read port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_ptr_r[IDX_W-1:0];
    if (dp_cmd.op == blkta_pkg::OP_FREE_RD) begin
      rd_en   = 1'b1;
      rd_addr = idx_full[IDX_W-1:0];
    end else if (dp_cmd.op == blkta_pkg::OP_SCAN) begin
      rd_en = rd_ptr_r < CNT_W'(NUM_BLOCKS);
    end
  end

  // Table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_ptr_r;
    wr_data = '0;
    case (dp_cmd.op)
      blkta_pkg::OP_CLEAR: begin
        wr_en = 1'b1;
      end
      blkta_pkg::OP_CLAIM_HIT: begin
        wr_en   = 1'b1;
        wr_addr = chk_idx_r;
        wr_data = {1'b1, item_owner_r};
      end
      blkta_pkg::OP_RELEASE_HIT: begin
        wr_en   = 1'b1;
        wr_addr = chk_idx_r;
      end
      blkta_pkg::OP_CLAIM_STEP: begin
        wr_en   = 1'b1;
        wr_data = {1'b1, item_owner_r};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Pointers and run tracking
  always_comb begin
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    left_nxt      = left_r;
    run_nxt       = run_r;
    run_start_nxt = run_start_r;
    if (chk_vld_r) begin
      if (rd_used) begin
        run_nxt = '0;
      end else begin
        run_nxt       = run_r + CNT_W'(1);
        run_start_nxt = run_start_sel;
      end
    end
    case (dp_cmd.op)
      blkta_pkg::OP_CLEAR: begin
        wr_ptr_nxt = wr_ptr_r + IDX_W'(1);
      end
      blkta_pkg::OP_ALLOC_INIT: begin
        rd_ptr_nxt = (item_ptr_r == '0) ? '0 : CNT_W'(idx_full + 32'd1);
      end
      blkta_pkg::OP_RANGE_INIT: begin
        rd_ptr_nxt = '0;
        run_nxt    = '0;
      end
      blkta_pkg::OP_SCAN: begin
        if (rd_en) begin
          rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
        end
      end
      blkta_pkg::OP_CLAIM_INIT: begin
        wr_ptr_nxt = run_start_sel;
        left_nxt   = CNT_W'(item_count_r);
      end
      blkta_pkg::OP_CLAIM_STEP: begin
        wr_ptr_nxt = wr_ptr_r + IDX_W'(1);
        left_nxt   = left_r - CNT_W'(1);
      end
      default: begin
        rd_ptr_nxt = rd_ptr_r;
      end
    endcase
  end

  // Result word
  assign addr_sum = ADDR_BITS'(base_r) + (ADDR_BITS'(res_idx_r) << log2_r);
  assign out_idx  = res_has_r ? blkta_pkg::IDX_FIELD_W'(res_idx_r) : '0;
  assign out_addr = res_has_r ? blkta_pkg::ADDR_FIELD_W'(addr_sum) : '0;

  // Table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
      chk_idx_r <= rd_addr;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_ptr_r    <= rd_ptr_nxt;
    run_r       <= run_nxt;
    run_start_r <= run_start_nxt;
    left_r      <= left_nxt;
    if (dp_cmd.op == blkta_pkg::OP_CAP) begin
      item_cmd_r   <= in_tdata[blkta_pkg::IN_CMD_LSB +: blkta_pkg::CMD_W];
      item_owner_r <= OWNER_BITS'(in_tdata[blkta_pkg::IN_PID_LSB +: blkta_pkg::PID_W]);
      item_ptr_r   <= in_tdata[blkta_pkg::IN_PTR_LSB +: blkta_pkg::PTR_W];
      item_count_r <= in_tdata[blkta_pkg::IN_COUNT_LSB +: blkta_pkg::COUNT_W];
    end
    if (dp_cmd.fin) begin
      res_status_r <= dp_cmd.fin_status;
      res_has_r    <= dp_cmd.fin_status == blkta_pkg::ST_DONE;
      res_idx_r    <= (dp_cmd.fin_src == blkta_pkg::SRC_RUN) ? run_start_r : chk_idx_r;
    end
    if (dp_cmd.load_out) begin
      out_tdata_r <= blkta_pkg::OUT_TDATA_W'({out_addr, out_idx, res_status_r});
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= blkta_pkg::BASE_RESET;
      log2_r      <= blkta_pkg::LOG2_RESET;
      chk_vld_r   <= 1'b0;
      wr_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == blkta_pkg::REG_BASE_ADDRESS) begin
          base_r <= cfg_data;
        end else if (cfg_index == blkta_pkg::REG_BLOCK_LOG2) begin
          log2_r <= cfg_data[blkta_pkg::LOG2_W-1:0];
        end
      end
      chk_vld_r <= rd_en;
      wr_ptr_r  <= wr_ptr_nxt;
      if (dp_cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result loaded over an unread word");

  a_release_checked: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == blkta_pkg::OP_RELEASE_HIT) |-> (chk_vld_r && rd_used))
    else $error("release of a block that was not read as used");

  a_claim_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == blkta_pkg::OP_CLAIM_STEP) |-> (32'(wr_ptr_r) < 32'(NUM_BLOCKS)))
    else $error("range claim beyond the table end");

  a_claim_hit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == blkta_pkg::OP_CLAIM_HIT) |-> (chk_vld_r && !rd_used))
    else $error("single claim of a block that is in use");
`endif

endmodule

// ----- rtl/blkta_ctrl.sv -----
// Controller: sequences clearing, decode, table scans, claims and result hand-off.
module blkta_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  blkta_pkg::dp_stat_t  dp_stat,
  output blkta_pkg::dp_cmd_t   dp_cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_A_SCAN,
    S_F_CHK,
    S_R_SCAN,
    S_R_CLAIM,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt         = state_r;
    dp_cmd.op         = blkta_pkg::OP_NONE;
    dp_cmd.fin        = 1'b0;
    dp_cmd.fin_status = blkta_pkg::ST_DONE;
    dp_cmd.fin_src    = blkta_pkg::SRC_CHK;
    dp_cmd.load_out   = 1'b0;
    in_tready         = 1'b0;
    case (state_r)
      S_CLEAR: begin
        dp_cmd.op = blkta_pkg::OP_CLEAR;
        if (dp_stat.wr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          dp_cmd.op = blkta_pkg::OP_CAP;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (dp_stat.item_cmd)
          blkta_pkg::CMD_ALLOC: begin
            if (dp_stat.start_oob) begin
              dp_cmd.fin        = 1'b1;
              dp_cmd.fin_status = blkta_pkg::ST_NOSPACE;
              state_nxt         = S_RESP;
            end else begin
              dp_cmd.op = blkta_pkg::OP_ALLOC_INIT;
              state_nxt = S_A_SCAN;
            end
          end
          blkta_pkg::CMD_FREE: begin
            if (dp_stat.free_oob) begin
              dp_cmd.fin        = 1'b1;
              dp_cmd.fin_status = blkta_pkg::ST_REJECT;
              state_nxt         = S_RESP;
            end else begin
              dp_cmd.op = blkta_pkg::OP_FREE_RD;
              state_nxt = S_F_CHK;
            end
          end
          blkta_pkg::CMD_RANGE: begin
            if (dp_stat.count_bad) begin
              dp_cmd.fin        = 1'b1;
              dp_cmd.fin_status = blkta_pkg::ST_NOSPACE;
              state_nxt         = S_RESP;
            end else begin
              dp_cmd.op = blkta_pkg::OP_RANGE_INIT;
              state_nxt = S_R_SCAN;
            end
          end
          default: begin
            dp_cmd.fin        = 1'b1;
            dp_cmd.fin_status = blkta_pkg::ST_REJECT;
            state_nxt         = S_RESP;
          end
        endcase
      end
      S_A_SCAN: begin
        dp_cmd.op = blkta_pkg::OP_SCAN;
        if (dp_stat.chk_vld && dp_stat.chk_free) begin
          dp_cmd.op  = blkta_pkg::OP_CLAIM_HIT;
          dp_cmd.fin = 1'b1;
          state_nxt  = S_RESP;
        end else if (dp_stat.chk_vld && dp_stat.chk_last) begin
          dp_cmd.op         = blkta_pkg::OP_NONE;
          dp_cmd.fin        = 1'b1;
          dp_cmd.fin_status = blkta_pkg::ST_NOSPACE;
          state_nxt         = S_RESP;
        end
      end
      S_F_CHK: begin
        dp_cmd.fin = 1'b1;
        if (dp_stat.chk_own) begin
          dp_cmd.op = blkta_pkg::OP_RELEASE_HIT;
        end else begin
          dp_cmd.fin_status = blkta_pkg::ST_REJECT;
        end
        state_nxt = S_RESP;
      end
      S_R_SCAN: begin
        dp_cmd.op = blkta_pkg::OP_SCAN;
        if (dp_stat.run_hit) begin
          dp_cmd.op = blkta_pkg::OP_CLAIM_INIT;
          state_nxt = S_R_CLAIM;
        end else if (dp_stat.chk_vld && dp_stat.chk_last) begin
          dp_cmd.op         = blkta_pkg::OP_NONE;
          dp_cmd.fin        = 1'b1;
          dp_cmd.fin_status = blkta_pkg::ST_NOSPACE;
          state_nxt         = S_RESP;
        end
      end
      S_R_CLAIM: begin
        dp_cmd.op = blkta_pkg::OP_CLAIM_STEP;
        if (dp_stat.claim_last) begin
          dp_cmd.fin     = 1'b1;
          dp_cmd.fin_src = blkta_pkg::SRC_RUN;
          state_nxt      = S_RESP;
        end
      end
      S_RESP: begin
        if (dp_stat.out_free) begin
          dp_cmd.load_out = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/block_tag_allocator_top.sv -----
// Top level of the block tag allocator: controller, datapath and port wiring.
// Throughput: one word at a time; the next is taken only after its result word has
//   loaded into the output register; the load waits while an unread word is held there.
//   The table port reads one entry a cycle.
// Reset: synchronous, active low; a clearing pass then zeroes the table, and no
//   input word is taken until it ends.
module block_tag_allocator_top #(
  parameter int NUM_BLOCKS = blkta_pkg::NUM_BLOCKS_DEF,
  parameter int OWNER_BITS = blkta_pkg::OWNER_BITS_DEF,
  parameter int ADDR_BITS  = blkta_pkg::ADDR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Command words
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] cmd, [9:2] process_id, [41:10] pointer, [48:42] count, rest zero
  input  logic [blkta_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Result words
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] status, [7:2] block_index, [39:8] block_address
  output logic [blkta_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // Register writes: 0 base_address, 1 block_size_log2
  input  logic                               cfg_we,
  input  logic [blkta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [blkta_pkg::CFG_DATA_W-1:0]   cfg_data
);

  blkta_pkg::dp_cmd_t  dp_cmd;
  blkta_pkg::dp_stat_t dp_stat;

  // Sequencer: clear pass, decode, scan, claim, hand result to the output register
  blkta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  // Table, counters and the output register that holds a word until taken
  blkta_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .OWNER_BITS (OWNER_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
